[hdl/utf16be_transcoder_unit_macros.svh]
// Assertion macros used by the checker file of the transcoder.
// No dependencies; include by bare file name.
`ifndef UTF16BE_TRANSCODER_UNIT_MACROS_SVH
`define UTF16BE_TRANSCODER_UNIT_MACROS_SVH

// Hold an immediate implication on every clock edge outside reset.
`define U16T_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("transcoder check failed");

// Hold a next-cycle implication on every clock edge outside reset.
`define U16T_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("transcoder check failed");

`endif

[hdl/u16t_pkg.sv]
// Shared types, constants and the UTF-8 encode function of the transcoder.
// No dependencies.
`timescale 1ns / 1ps

package u16t_pkg;

  localparam int unsigned MaxBytes = 4;
  localparam int unsigned CntW     = $clog2(MaxBytes + 1);

  // Top six bits of a high surrogate (D800-DBFF).
  localparam logic [5:0] HiSurrTag = 6'b110110;

  localparam logic OutModeUtf8    = 1'b0;
  localparam logic OutModeUtf16Le = 1'b1;

  // Bytes of one input item, byte 0 leaves first.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          count;
    logic                     unpaired;
  } u16t_burst_t;

  function automatic u16t_burst_t u16t_utf8_enc(input logic [20:0] cp, input logic unp);
    u16t_burst_t b;
    b = '0;
    b.unpaired = unp;
    if (cp < 21'h80) begin
      b.bytes[0] = cp[7:0];
      b.count    = CntW'(1);
    end else if (cp < 21'h800) begin
      b.bytes[0] = {3'b110, cp[10:6]};
      b.bytes[1] = {2'b10, cp[5:0]};
      b.count    = CntW'(2);
    end else if (cp < 21'h10000) begin
      b.bytes[0] = {4'b1110, cp[15:12]};
      b.bytes[1] = {2'b10, cp[11:6]};
      b.bytes[2] = {2'b10, cp[5:0]};
      b.count    = CntW'(3);
    end else begin
      b.bytes[0] = {5'b11110, cp[20:18]};
      b.bytes[1] = {2'b10, cp[17:12]};
      b.bytes[2] = {2'b10, cp[11:6]};
      b.bytes[3] = {2'b10, cp[5:0]};
      b.count    = CntW'(4);
    end
    return b;
  endfunction

endpackage

[hdl/u16t_decode.sv]
// Code unit decoder: surrogate pairing state and byte burst generation.
// Depends on u16t_pkg.
`timescale 1ns / 1ps

module u16t_decode import u16t_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        mode_i,
  input  logic [15:0] unit_i,
  input  logic        eos_i,
  input  logic        step_i,
  output u16t_burst_t burst_o
);

  logic [9:0] held_high_q, held_high_d;
  logic       held_valid_q, held_valid_d;
  logic [20:0] pair_cp;

  assign pair_cp = 21'h10000 + {1'b0, held_high_q, unit_i[9:0]};

  always_comb begin
    burst_o      = '0;
    held_high_d  = held_high_q;
    held_valid_d = held_valid_q;
    if (mode_i == OutModeUtf16Le) begin
      burst_o.bytes[0] = unit_i[7:0];
      burst_o.bytes[1] = unit_i[15:8];
      burst_o.count    = CntW'(2);
    end else if (held_valid_q) begin
      burst_o      = u16t_utf8_enc(pair_cp, 1'b0);
      held_valid_d = 1'b0;
      held_high_d  = '0;
    end else if (unit_i[15:10] == HiSurrTag) begin
      if (eos_i) begin
        burst_o = u16t_utf8_enc({5'd0, unit_i}, 1'b1);
      end else begin
        held_valid_d = 1'b1;
        held_high_d  = unit_i[9:0];
      end
    end else begin
      burst_o = u16t_utf8_enc({5'd0, unit_i}, 1'b0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_high_q  <= '0;
      held_valid_q <= 1'b0;
    end else if (step_i) begin
      held_high_q  <= held_high_d;
      held_valid_q <= held_valid_d;
    end
  end

endmodule

[hdl/u16t_serial.sv]
// Byte serialiser: loads one burst and sends it out one byte per transfer.
// Depends on u16t_pkg.
`timescale 1ns / 1ps

module u16t_serial import u16t_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  u16t_burst_t burst_i,
  input  logic        in_valid_i,
  output logic        take_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] out_byte
  output logic        m_axis_tlast_o,   // last_of_run
  output logic        m_axis_tuser_o    // [0] unpaired
);

  logic [MaxBytes-1:0][7:0] bytes_q, bytes_d;
  logic [CntW-1:0]          rem_q, rem_d;
  logic                     unp_q, unp_d;
  logic                     xfer;

  assign m_axis_tvalid_o = (rem_q != '0);
  assign m_axis_tdata_o  = bytes_q[0];
  assign m_axis_tlast_o  = (rem_q == CntW'(1));
  assign m_axis_tuser_o  = unp_q;

  assign xfer   = m_axis_tvalid_o && m_axis_tready_i;
  // Reload once the buffer is empty or its final byte leaves this cycle.
  assign take_o = in_valid_i && ((rem_q == '0) || (m_axis_tlast_o && m_axis_tready_i));

  always_comb begin
    bytes_d = bytes_q;
    rem_d   = rem_q;
    unp_d   = unp_q;
    if (take_o) begin
      bytes_d = burst_i.bytes;
      rem_d   = burst_i.count;
      unp_d   = burst_i.unpaired;
    end else if (xfer) begin
      bytes_d = {8'h00, bytes_q[MaxBytes-1:1]};
      rem_d   = rem_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
    unp_q   <= unp_d;
  end

endmodule

[hdl/utf16be_transcoder_unit.sv]
// UTF-16 code unit transcoder, top level: input register, decoder, serialiser.
// Depends on u16t_pkg, u16t_decode and u16t_serial.
`timescale 1ns / 1ps

// Converts a stream of UTF-16 code units (already assembled from big-endian
// byte pairs) into UTF-8 (output_mode 0) or UTF-16LE (output_mode 1), one byte
// per output transfer. In UTF-8 mode a high surrogate gives no bytes and is
// paired with the next unit, whatever it is, giving four bytes; a high
// surrogate flagged with tlast is sent as its own three bytes with tuser set.
// tlast on the output marks the final byte caused by one input unit. A unit
// yields one to four bytes (two in UTF-16LE mode) and a held surrogate none;
// the bytes go out one per transfer, held while tready is low. A new unit is
// taken in the same cycle as the final byte of the previous one leaves, so
// bursts follow without gaps, except after a held surrogate.
// Write output_mode only with the block idle.

module utf16be_transcoder_unit import u16t_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel
  input  logic        cfg_wvalid_i,
  output logic        cfg_wready_o,
  input  logic        cfg_wdata_i,      // [0] output_mode
  // Input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] code_unit
  input  logic        s_axis_tlast_i,   // end_of_stream
  // Output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] out_byte
  output logic        m_axis_tlast_o,   // last_of_run
  output logic        m_axis_tuser_o    // [0] unpaired
);

  logic        mode_q;
  logic [15:0] unit_q;
  logic        eos_q;
  logic        in_valid_q;
  logic        take;
  u16t_burst_t burst;

  // Configuration is always accepted.
  assign cfg_wready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= OutModeUtf8;
    end else if (cfg_wvalid_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // Input register: refill when empty or when its unit moves on this cycle.
  assign s_axis_tready_o = !in_valid_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_q <= 1'b1;
    end else if (take) begin
      in_valid_q <= 1'b0;
    end
  end

  // Payload: hold unless a new transfer arrives.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      unit_q <= s_axis_tdata_i;
      eos_q  <= s_axis_tlast_i;
    end
  end

  u16t_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .mode_i  (mode_q),
    .unit_i  (unit_q),
    .eos_i   (eos_q),
    .step_i  (take),
    .burst_o (burst)
  );

  u16t_serial u_serial (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .burst_i         (burst),
    .in_valid_i      (in_valid_q),
    .take_o          (take),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

[hdl/u16t_checker.sv]
// Port-level checker for the transcoder and its bind to the top level.
// Depends on utf16be_transcoder_unit_macros.svh.
`timescale 1ns / 1ps
`include "utf16be_transcoder_unit_macros.svh"

module u16t_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o,
  input logic       m_axis_tuser_o
);

  // A stalled output transfer keeps its byte and flags.
  `U16T_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o) && $stable(m_axis_tuser_o))

  // With no byte pending the input side must be open.
  `U16T_ASSERT_IMP(a_ready_when_drained, clk_i, rst_ni, !m_axis_tvalid_o, s_axis_tready_o)

  // An unpaired surrogate goes out as ED followed by continuation bytes.
  `U16T_ASSERT_IMP(a_unpaired_form, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o, (m_axis_tdata_o == 8'hED) || (m_axis_tdata_o[7:6] == 2'b10))

endmodule

bind utf16be_transcoder_unit u16t_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
